@@ rtl/assert_macros.svh @@
// assertion macros used by the spiral point generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spiral point generator check failed");
`define SPG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("spiral point generator forbidden condition");
`else
`define SPG_ASSERT(lbl, prop)
`define SPG_ASSERT_NEVER(lbl, cond)
`endif
`endif

@@ rtl/spg_pkg.sv @@
// ----------------------------------------------------------------------------
// spg_pkg
// types and constants of the spiral point generator
// ----------------------------------------------------------------------------
`default_nettype none
package spg_pkg;

  typedef enum logic [1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_GROWTH      = 2'd1,
    REG_TURNS       = 2'd2
  } cfg_reg_e;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned PhaseW    = 24;
  localparam int unsigned RadW      = 31;
  localparam int unsigned CordW     = 34;
  localparam int unsigned AngW      = 32;
  localparam int unsigned AtanLen   = 30;

  localparam logic [31:0] TWO_PI_Q29    = 32'hC90FDAA2;
  localparam logic [CordW-1:0] GAIN_Q30 = 34'h026DD3B6A;

  typedef logic [15:0] cfg_word_t;

  // atan(2^-k) in units of 2^-32 turn
  function automatic logic signed [AngW-1:0] atan_turns(input logic [4:0] k);
    logic signed [AngW-1:0] a;
    case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ rtl/spiral_point_generator.sv @@
// start runs through stages 0 and 1, the divider, stage a, the cordic and sp to the output
// throughput: one point index per cycle, busy never rises
// the 24-stage restoring divider and the CORDIC_STAGES rotation stages set the latency
// reset clears all valid bits and loads the register defaults
// the receiver cannot stall, every result shows for one cycle
// ----------------------------------------------------------------------------
// spiral_point_generator
// pipelined archimedean spiral point generator with cordic sine and cosine
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module spiral_point_generator #(
  parameter int unsigned CORDIC_STAGES = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [15:0]                   point_index_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [spg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i,
  output logic                               out_valid_o,
  output logic signed [31:0]                 x_pos_o,
  output logic signed [31:0]                 y_pos_o,
  output logic                               out_of_range_o
);
  import spg_pkg::*;

  localparam int unsigned DivSteps = PhaseW;

  // configuration registers
  cfg_word_t point_count_q, growth_q, turns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= 16'd500;
      growth_q      <= 16'd1311;
      turns_q       <= 16'd1280;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_POINT_COUNT: point_count_q <= cfg_data_i;
        REG_GROWTH:      growth_q      <= cfg_data_i;
        REG_TURNS:       turns_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // stage 0: capture index
  logic        s0_vld_q;
  logic        s0_oor_q;
  logic [15:0] s0_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_vld_q <= 1'b0;
    else         s0_vld_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    s0_idx_q <= point_index_i;
    s0_oor_q <= point_index_i >= point_count_q;
  end

  // stage 1: turns * index
  logic        s1_vld_q;
  logic        s1_oor_q;
  logic [31:0] s1_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else         s1_vld_q <= s0_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s1_prod_q <= turns_q * s0_idx_q;
    s1_oor_q  <= s0_oor_q;
  end

  // restoring divider, one quotient bit per stage; word shifts out dividend
  // bits and shifts in quotient bits
  logic              dv_vld_q [DivSteps+1];
  logic              dv_oor_q [DivSteps+1];
  logic [15:0]       dv_rem_q [DivSteps+1];
  logic [PhaseW-1:0] dv_wrd_q [DivSteps+1];

  always_comb begin
    dv_vld_q[0] = s1_vld_q;
    dv_oor_q[0] = s1_oor_q;
    dv_rem_q[0] = s1_prod_q[31:16];
    dv_wrd_q[0] = {s1_prod_q[15:0], 8'd0};
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    logic [16:0] trial;
    logic        qbit;
    always_comb begin
      trial = {dv_rem_q[i], dv_wrd_q[i][PhaseW-1]};
      qbit  = trial >= {1'b0, point_count_q};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_vld_q[i+1] <= 1'b0;
      else         dv_vld_q[i+1] <= dv_vld_q[i];
    end
    always_ff @(posedge clk_i) begin
      dv_oor_q[i+1] <= dv_oor_q[i];
      dv_rem_q[i+1] <= qbit ? 16'(trial - {1'b0, point_count_q}) : trial[15:0];
      dv_wrd_q[i+1] <= {dv_wrd_q[i][PhaseW-2:0], qbit};
    end
  end

  // stage a: angle and cordic setup
  logic              sa_vld_q;
  logic              sa_oor_q;
  logic [RadW-1:0]   sa_ang_q;
  logic [1:0]        sa_quad_q;
  logic [AngW-1:0]   sa_z_q;
  logic [55:0]       ang_full;

  assign ang_full = dv_wrd_q[DivSteps] * TWO_PI_Q29;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sa_vld_q <= 1'b0;
    else         sa_vld_q <= dv_vld_q[DivSteps];
  end

  always_ff @(posedge clk_i) begin
    sa_oor_q  <= dv_oor_q[DivSteps];
    sa_ang_q  <= ang_full[55:25];
    sa_quad_q <= dv_wrd_q[DivSteps][15:14];
    sa_z_q    <= {2'b00, dv_wrd_q[DivSteps][13:0], 16'd0};
  end

  // cordic pipeline, entry 0 also forms the radius
  logic                    cd_vld_q  [CORDIC_STAGES+1];
  logic                    cd_oor_q  [CORDIC_STAGES+1];
  logic [RadW-1:0]         cd_rad_q  [CORDIC_STAGES+1];
  logic [1:0]              cd_quad_q [CORDIC_STAGES+1];
  logic signed [CordW-1:0] cd_x_q    [CORDIC_STAGES+1];
  logic signed [CordW-1:0] cd_y_q    [CORDIC_STAGES+1];
  logic signed [AngW-1:0]  cd_z_q    [CORDIC_STAGES+1];
  logic [46:0]             rad_full;

  assign rad_full = growth_q * sa_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cd_vld_q[0] <= 1'b0;
    else         cd_vld_q[0] <= sa_vld_q;
  end

  always_ff @(posedge clk_i) begin
    cd_oor_q[0]  <= sa_oor_q;
    cd_rad_q[0]  <= rad_full[46:16];
    cd_quad_q[0] <= sa_quad_q;
    cd_x_q[0]    <= GAIN_Q30;
    cd_y_q[0]    <= '0;
    cd_z_q[0]    <= sa_z_q;
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    logic signed [CordW-1:0] dx, dy;
    logic signed [AngW-1:0]  at;
    logic                    pos;
    always_comb begin
      dx  = cd_y_q[k] >>> k;
      dy  = cd_x_q[k] >>> k;
      at  = atan_turns(5'(k));
      pos = !cd_z_q[k][AngW-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cd_vld_q[k+1] <= 1'b0;
      else         cd_vld_q[k+1] <= cd_vld_q[k];
    end
    always_ff @(posedge clk_i) begin
      cd_oor_q[k+1]  <= cd_oor_q[k];
      cd_rad_q[k+1]  <= cd_rad_q[k];
      cd_quad_q[k+1] <= cd_quad_q[k];
      if (pos) begin
        cd_x_q[k+1] <= cd_x_q[k] - dx;
        cd_y_q[k+1] <= cd_y_q[k] + dy;
        cd_z_q[k+1] <= cd_z_q[k] - at;
      end else begin
        cd_x_q[k+1] <= cd_x_q[k] + dx;
        cd_y_q[k+1] <= cd_y_q[k] - dy;
        cd_z_q[k+1] <= cd_z_q[k] + at;
      end
    end
  end

  // quadrant fold and radius products
  logic signed [CordW-1:0] cos_v, sin_v, fx, fy;
  logic signed [RadW:0]    rad_s;

  always_comb begin
    fx = cd_x_q[CORDIC_STAGES];
    fy = cd_y_q[CORDIC_STAGES];
    case (cd_quad_q[CORDIC_STAGES])
      2'd0: begin cos_v = fx;  sin_v = fy;  end
      2'd1: begin cos_v = -fy; sin_v = fx;  end
      2'd2: begin cos_v = -fx; sin_v = -fy; end
      default: begin cos_v = fy; sin_v = -fx; end
    endcase
    rad_s = signed'({1'b0, cd_rad_q[CORDIC_STAGES]});
  end

  logic                    sp_vld_q;
  logic                    sp_oor_q;
  logic signed [65:0]      sp_px_q, sp_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sp_vld_q <= 1'b0;
    else         sp_vld_q <= cd_vld_q[CORDIC_STAGES];
  end

  always_ff @(posedge clk_i) begin
    sp_oor_q <= cd_oor_q[CORDIC_STAGES];
    sp_px_q  <= rad_s * cos_v;
    sp_py_q  <= rad_s * sin_v;
  end

  // floor shift and saturation
  function automatic logic signed [31:0] sat_shift(input logic signed [65:0] p);
    logic signed [35:0] v;
    logic signed [31:0] r;
    v = 36'(p >>> 30);
    if (v > 36'sh07FFFFFFF)      r = 32'sh7FFFFFFF;
    else if (v < -36'sh080000000) r = 32'sh80000000;
    else                          r = v[31:0];
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else         out_valid_o <= sp_vld_q;
  end

  always_ff @(posedge clk_i) begin
    out_of_range_o <= sp_oor_q;
    x_pos_o        <= sp_oor_q ? '0 : sat_shift(sp_px_q);
    y_pos_o        <= sp_oor_q ? '0 : sat_shift(sp_py_q);
  end

  `SPG_ASSERT(a_start_enters, (start && !busy) |=> s0_vld_q)
  `SPG_ASSERT(a_div_to_angle, dv_vld_q[DivSteps] |=> sa_vld_q)
  `SPG_ASSERT_NEVER(a_oor_zero, out_valid_o && out_of_range_o && (x_pos_o != 0 || y_pos_o != 0))

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// spiral point generator testbench
// drives point indexes through the command port under random gaps and checks
// every x, y and out-of-range word against an internal fixed-point predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import spg_pkg::*;

  localparam int Stages  = 20;
  localparam int Latency = Stages + 30;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               oor;
  } point_t;

  typedef struct {
    bit        is_cfg;
    bit        drain;
    cfg_reg_e  reg_sel;
    logic [15:0] value;
  } job_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  logic [15:0] point_index_i = '0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic out_valid_o;
  logic signed [31:0] x_pos_o, y_pos_o;
  logic out_of_range_o;

  spiral_point_generator #(.CORDIC_STAGES(Stages)) dut (.*);

  always #6 clk_i = ~clk_i;

  job_t   pending_jobs[$];
  point_t expected_points[$];
  int     errors = 0;
  int     send_idle_pct = 10;
  bit     stim_done = 0;
  logic [15:0] n_points = 16'd500, gain = 16'd1311, n_turns = 16'd1280;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic point_t spiral_point(input logic [15:0] idx);
    point_t p;
    logic [63:0] phase, angle, radius;
    logic signed [63:0] cx, cy, z, dx, dy, c, s, xv, yv;
    logic [1:0] quad;
    p.x = 0; p.y = 0; p.oor = 1;
    if (idx >= n_points) return p;
    phase  = ((64'(n_turns) * idx) << 8) / n_points;
    angle  = (phase * 64'hC90FDAA2) >> 25;
    radius = (64'(gain) * angle) >> 16;
    quad = phase[15:14];
    z  = 64'(phase[13:0]) << 16;
    cx = 64'h26DD3B6A;
    cy = 0;
    for (int k = 0; k < Stages && k < 30; k++) begin
      dx = cy >>> k;
      dy = cx >>> k;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= 64'(atan_turns(5'(k)));
      end else begin
        cx += dx; cy -= dy; z += 64'(atan_turns(5'(k)));
      end
    end
    case (quad)
      2'd0: begin c = cx;  s = cy;  end
      2'd1: begin c = -cy; s = cx;  end
      2'd2: begin c = -cx; s = -cy; end
      default: begin c = cy; s = -cx; end
    endcase
    xv = ($signed(radius) * c) >>> 30;
    yv = ($signed(radius) * s) >>> 30;
    p.x = xv > 64'sh7FFFFFFF ? 32'h7FFFFFFF : xv < -64'sh80000000 ? 32'h80000000 : xv[31:0];
    p.y = yv > 64'sh7FFFFFFF ? 32'h7FFFFFFF : yv < -64'sh80000000 ? 32'h80000000 : yv[31:0];
    p.oor = 0;
    return p;
  endfunction

  // driver: at most one job per falling edge, config only once the pipeline is empty
  int quiet_cycles = 0;
  always @(negedge clk_i) begin
    job_t j;
    logic start_d;
    logic cfg_valid_d;
    if (out_valid_o || start) quiet_cycles = 0;
    else quiet_cycles++;
    if (rst_ni) begin
      start_d     = start && busy;
      cfg_valid_d = cfg_valid_i && !cfg_ready_o;
      if (!cfg_valid_d && !start_d && pending_jobs.size() > 0) begin
        j = pending_jobs[0];
        if (j.is_cfg || j.drain) begin
          if (expected_points.size() == 0 && quiet_cycles > Latency + 4 && !start) begin
            void'(pending_jobs.pop_front());
            if (j.is_cfg) begin
              cfg_valid_d = 1;
              cfg_index_i <= j.reg_sel;
              cfg_data_i  <= j.value;
              case (j.reg_sel)
                REG_POINT_COUNT: n_points = j.value;
                REG_GROWTH:      gain = j.value;
                default:         n_turns = j.value;
              endcase
            end
          end
        end else if ($urandom_range(99) >= send_idle_pct && !cfg_valid_i) begin
          void'(pending_jobs.pop_front());
          start_d = 1;
          point_index_i <= j.value;
          expected_points = {expected_points, spiral_point(j.value)};
        end
      end
      start       <= start_d;
      cfg_valid_i <= cfg_valid_d;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      point_t e;
      if (expected_points.size() == 0) report("result word with nothing expected");
      else begin
        e = expected_points.pop_front();
        if (x_pos_o !== e.x) report($sformatf("x got %h want %h", x_pos_o, e.x));
        if (y_pos_o !== e.y) report($sformatf("y got %h want %h", y_pos_o, e.y));
        if (out_of_range_o !== e.oor)
          report($sformatf("out_of_range got %b want %b", out_of_range_o, e.oor));
      end
    end
  end

  task automatic add_point(input logic [15:0] idx);
    job_t j;
    j = '{is_cfg: 0, drain: 0, reg_sel: REG_POINT_COUNT, value: idx};
    pending_jobs = {pending_jobs, j};
  endtask

  task automatic add_cfg(input cfg_reg_e r, input logic [15:0] v);
    job_t j;
    j = '{is_cfg: 1, drain: 0, reg_sel: r, value: v};
    pending_jobs = {pending_jobs, j};
  endtask

  task automatic add_drain();
    job_t j;
    j = '{is_cfg: 0, drain: 1, reg_sel: REG_POINT_COUNT, value: 0};
    pending_jobs = {pending_jobs, j};
  endtask

  task automatic wait_empty();
    while (pending_jobs.size() > 0 || start) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] cnt;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    // directed: reset settings, edges of the index, every quadrant
    add_point(0); add_point(1); add_point(124); add_point(125); add_point(250);
    add_point(375); add_point(499); add_point(500); add_point(16'hFFFF);
    add_drain();
    // zero point count: all out of range
    add_cfg(REG_POINT_COUNT, 0);
    add_point(0); add_point(16'hFFFF);
    // extremes, saturation
    add_cfg(REG_POINT_COUNT, 16'hFFFF);
    add_cfg(REG_GROWTH, 16'hFFFF);
    add_cfg(REG_TURNS, 16'hFFFF);
    add_point(16'hFFFE); add_point(16'hFFFF); add_point(16'h8000); add_point(16'h5555);
    add_cfg(REG_GROWTH, 0);
    add_cfg(REG_TURNS, 0);
    add_point(16'hAAAA); add_point(1);
    add_cfg(REG_POINT_COUNT, 1);
    add_cfg(REG_TURNS, 16'h0100);
    add_cfg(REG_GROWTH, 16'h8000);
    add_point(0); add_point(1);
    add_drain();
    wait_empty();
    // random phases with rotating configuration
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = ph < 2 ? 10 : (ph < 4 ? 83 : 0);
      cnt = $urandom_range(3) == 0 ? 16'($urandom_range(1, 65535))
                                   : 16'($urandom_range(1, 2000));
      add_cfg(REG_POINT_COUNT, cnt);
      add_cfg(REG_GROWTH, 16'($urandom));
      add_cfg(REG_TURNS, 16'($urandom));
      for (int i = 0; i < 100; i++)
        add_point($urandom_range(9) == 0 ? 16'($urandom)
                                         : 16'($urandom_range(0, cnt - 1)));
      wait_empty();
    end
    while (expected_points.size() > 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
